>>> hw/rtl/fpn3_pkg.sv
// ----------------------------------------------------------------------------
// fpn3_pkg: shared types and constants of the layered 3D gradient noise block
// Holds the hash constants, register indexes, setup state and setup status.
// ----------------------------------------------------------------------------
package fpn3_pkg;

	// Multipliers of the corner hash, one per axis (x, y, z).
	localparam logic [31:0] HASH_K [3] = '{32'd374761393, 32'd668265263, 32'd1274126177};

	localparam int ONE_Q16 = 65536;

	// Width of an octave count; covers up to sixteen octaves.
	localparam int OCT_W = 5;
	// Width of the amplitude total, sixteen octaves of at most 1.0 each.
	localparam int TOT_W = 21;
	// Register stages inside one octave lane.
	localparam int LANE_STG = 7;
	// The normalization reciprocal is 2^DIV_EXP / total.
	localparam int DIV_EXP = 48;
	localparam int DIV_CNT_W = 6;
	localparam int RECIP_W = 33;

	localparam int CFG_IDX_W = 3;
	localparam logic [CFG_IDX_W-1:0] REG_SEED   = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_OCTAVE = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_FREQ   = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_AMP    = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_RIDGED = 3'd4;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_TABLE,
		ST_DIVIDE
	} setup_state_t;

	typedef struct packed {
		logic                busy;
		logic [31:0]         seed;
		logic                ridged;
		logic [OCT_W-1:0]    oct_used;
		logic [RECIP_W-1:0]  recip;
	} setup_t;

endpackage

>>> hw/rtl/fpn3_octave.sv
// ----------------------------------------------------------------------------
// fpn3_octave: one octave of 3D gradient noise
// Seven-stage lane: lattice scaling, corner hashing, fade curves, gradients
// and trilinear blending, giving the octave value in unsigned Q1.16 [0,1].
// ----------------------------------------------------------------------------
module fpn3_octave #(
	parameter int FRAC_BITS = 16
) (
	input  logic                         clk,
	input  logic [fpn3_pkg::LANE_STG:1]  en,
	input  logic signed [31:0]           px,
	input  logic signed [31:0]           py,
	input  logic signed [31:0]           pz,
	input  logic [31:0]                  freq,
	input  logic [31:0]                  seed,
	output logic [16:0]                  nv
);
	import fpn3_pkg::*;

	localparam int E_W = 20;
	localparam logic [19:0] FADE_15 = 20'd983040;
	localparam logic [19:0] FADE_10 = 20'd655360;
	localparam logic signed [E_W-1:0] ONE_E = E_W'(ONE_Q16);

	// Two far-corner terms of -1.0 each negate to +2.0, so the sum outgrows 18 bits and is kept in E_W bits.
	function automatic logic signed [E_W-1:0] grad(input logic [3:0] h,
			input logic signed [17:0] a, input logic signed [17:0] b,
			input logic signed [17:0] c);
		logic signed [E_W-1:0] p;
		logic signed [E_W-1:0] q;
		p = (h < 4'd8) ? E_W'(a) : E_W'(b);
		q = (h < 4'd4) ? E_W'(b) : ((h == 4'd12 || h == 4'd14) ? E_W'(a) : E_W'(c));
		if (h[0]) p = -p;
		if (h[1]) q = -q;
		return p + q;
	endfunction

	// a + floor(t * (b - a) / 2^16)
	function automatic logic signed [E_W-1:0] blend(input logic signed [E_W-1:0] a,
			input logic signed [E_W-1:0] b, input logic [19:0] t);
		logic signed [E_W:0]    d;
		logic signed [E_W+21:0] p;
		d = {b[E_W-1], b} - {a[E_W-1], a};
		p = $signed({1'b0, t}) * d;
		return a + E_W'(p >>> 16);
	endfunction

	logic signed [31:0] pt [3];
	assign pt[0] = px;
	assign pt[1] = py;
	assign pt[2] = pz;

	// Stage 1: scale the point and split off lattice cell and fraction.
	logic signed [64:0] prod [3];
	logic [7:0]  cell_d [3];
	logic [15:0] frac_d [3];
	logic [7:0]  cell_s1 [3];
	logic [15:0] frac_s1 [3];

	always_comb begin
		for (int k = 0; k < 3; k++) begin
			prod[k]   = pt[k] * $signed({1'b0, freq});
			cell_d[k] = prod[k][FRAC_BITS+23 -: 8];
			frac_d[k] = prod[k][FRAC_BITS+15 -: 16];
		end
	end

	always_ff @(posedge clk) begin
		if (en[1]) begin
			cell_s1 <= cell_d;
			frac_s1 <= frac_d;
		end
	end

	// Stage 2: first hash step for all eight corners, first fade products.
	logic [31:0] amul [3][2];
	logic [31:0] h1_d [8];
	logic [31:0] sq [3];
	logic [19:0] bw [3];
	logic [35:0] tbp [3];
	logic [31:0] h1_s2 [8];
	logic [15:0] tt_s2 [3];
	logic [19:0] tb_s2 [3];
	logic [15:0] frac_s2 [3];

	always_comb begin
		for (int k = 0; k < 3; k++) begin
			amul[k][0] = {24'd0, cell_s1[k]} * HASH_K[k];
			amul[k][1] = amul[k][0] + HASH_K[k];
			sq[k]      = {16'd0, frac_s1[k]} * {16'd0, frac_s1[k]};
			bw[k]      = FADE_15 - ({4'd0, frac_s1[k]} * 20'd6);
			tbp[k]     = {20'd0, frac_s1[k]} * {16'd0, bw[k]};
		end
		for (int c = 0; c < 8; c++) begin
			h1_d[c] = seed ^ amul[0][c[0]] ^ amul[1][c[1]] ^ amul[2][c[2]];
		end
	end

	always_ff @(posedge clk) begin
		if (en[2]) begin
			h1_s2 <= h1_d;
			for (int k = 0; k < 3; k++) begin
				tt_s2[k] <= sq[k][31:16];
				tb_s2[k] <= tbp[k][35:16];
			end
			frac_s2 <= frac_s1;
		end
	end

	// Stage 3: hash mixing multiply (only the low bits feed the gradient pick).
	logic [19:0] hx [8];
	logic [19:0] m_d [8];
	logic [31:0] t3p [3];
	logic [19:0] m_s3 [8];
	logic [15:0] t3_s3 [3];
	logic [19:0] fa_s3 [3];
	logic [15:0] frac_s3 [3];

	always_comb begin
		for (int c = 0; c < 8; c++) begin
			hx[c]  = h1_s2[c][19:0] ^ {1'b0, h1_s2[c][31:13]};
			m_d[c] = hx[c] * HASH_K[2][19:0];
		end
		for (int k = 0; k < 3; k++) begin
			t3p[k] = {16'd0, tt_s2[k]} * {16'd0, frac_s2[k]};
		end
	end

	always_ff @(posedge clk) begin
		if (en[3]) begin
			m_s3 <= m_d;
			for (int k = 0; k < 3; k++) begin
				t3_s3[k] <= t3p[k][31:16];
				fa_s3[k] <= FADE_10 - tb_s2[k];
			end
			frac_s3 <= frac_s2;
		end
	end

	// Stage 4: corner gradients and final fade products.
	logic signed [17:0] d0 [3];
	logic signed [17:0] d1 [3];
	logic [3:0]  hk [8];
	logic signed [E_W-1:0] g_d [8];
	logic [35:0] fdp [3];
	logic signed [E_W-1:0] g_s4 [8];
	logic [19:0] fade_s4 [3];

	always_comb begin
		for (int k = 0; k < 3; k++) begin
			d0[k]  = $signed({2'b00, frac_s3[k]});
			d1[k]  = d0[k] - 18'sd65536;
			fdp[k] = {20'd0, t3_s3[k]} * {16'd0, fa_s3[k]};
		end
		for (int c = 0; c < 8; c++) begin
			hk[c]  = m_s3[c][3:0] ^ m_s3[c][19:16];
			g_d[c] = grad(hk[c], c[0] ? d1[0] : d0[0], c[1] ? d1[1] : d0[1],
				c[2] ? d1[2] : d0[2]);
		end
	end

	always_ff @(posedge clk) begin
		if (en[4]) begin
			g_s4 <= g_d;
			for (int k = 0; k < 3; k++) begin
				fade_s4[k] <= fdp[k][35:16];
			end
		end
	end

	// Stage 5: blend along x.
	logic signed [E_W-1:0] e_s5 [4];
	logic [19:0] fv_s5;
	logic [19:0] fw_s5;

	always_ff @(posedge clk) begin
		if (en[5]) begin
			for (int j = 0; j < 4; j++) begin
				e_s5[j] <= blend(g_s4[2*j], g_s4[2*j+1], fade_s4[0]);
			end
			fv_s5 <= fade_s4[1];
			fw_s5 <= fade_s4[2];
		end
	end

	// Stage 6: blend along y.
	logic signed [E_W-1:0] f_s6 [2];
	logic [19:0] fw_s6;

	always_ff @(posedge clk) begin
		if (en[6]) begin
			f_s6[0] <= blend(e_s5[0], e_s5[1], fv_s5);
			f_s6[1] <= blend(e_s5[2], e_s5[3], fv_s5);
			fw_s6   <= fw_s5;
		end
	end

	// Stage 7: blend along z, clamp to [-1,1] and map to [0,1].
	logic signed [E_W-1:0] l_d;
	logic signed [E_W-1:0] lc;
	logic [E_W-1:0] lsum;
	logic [16:0] nv_s7;

	always_comb begin
		l_d = blend(f_s6[0], f_s6[1], fw_s6);
		if (l_d > ONE_E) begin
			lc = ONE_E;
		end else if (l_d < -ONE_E) begin
			lc = -ONE_E;
		end else begin
			lc = l_d;
		end
		lsum = E_W'(lc + ONE_E);
	end

	always_ff @(posedge clk) begin
		if (en[7]) begin
			nv_s7 <= lsum[17:1];
		end
	end

	assign nv = nv_s7;

endmodule

>>> hw/rtl/fpn3_setup.sv
// ----------------------------------------------------------------------------
// fpn3_setup: configuration registers and per-octave coefficient tables
// After reset and after every write to a defined register it walks the
// octaves to build the frequency and amplitude tables, then divides out the
// normalization reciprocal one quotient bit per cycle.
// ----------------------------------------------------------------------------
module fpn3_setup #(
	parameter int MAX_OCTAVES = 8
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_we,
	input  logic [fpn3_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [31:0]                       cfg_wdata,
	output fpn3_pkg::setup_t                  setup,
	output logic [31:0]                       freq_tab [MAX_OCTAVES],
	output logic [16:0]                       amp_tab [MAX_OCTAVES]
);
	import fpn3_pkg::*;

	localparam int IDX_W = (MAX_OCTAVES > 1) ? $clog2(MAX_OCTAVES) : 1;

	logic [31:0] seed_q;
	logic [3:0]  count_q;
	logic [15:0] fmul_q;
	logic [15:0] amul_q;
	logic        ridged_q;

	setup_state_t state_q, state_d;
	logic [IDX_W-1:0]     tab_idx_q;
	logic [DIV_CNT_W-1:0] div_cnt_q;
	logic [31:0]          cur_freq_q;
	logic [16:0]          cur_amp_q;
	logic [TOT_W-1:0]     total_q;
	logic [TOT_W-1:0]     rem_q;
	logic [RECIP_W-1:0]   quo_q;

	logic             cfg_hit;
	logic [OCT_W-1:0] oct_used;
	logic [47:0]      fprod;
	logic [32:0]      aprod;
	logic [31:0]      next_freq;
	logic [TOT_W:0]   trial;

	always_comb begin
		case (cfg_index)
			REG_SEED, REG_OCTAVE, REG_FREQ, REG_AMP, REG_RIDGED: cfg_hit = cfg_we;
			default: cfg_hit = 1'b0;
		endcase
	end

	always_comb begin
		if (count_q == 4'd0) begin
			oct_used = OCT_W'(1);
		end else if ({1'b0, count_q} > OCT_W'(MAX_OCTAVES)) begin
			oct_used = OCT_W'(MAX_OCTAVES);
		end else begin
			oct_used = {1'b0, count_q};
		end
	end

	always_comb begin
		fprod = cur_freq_q * {32'd0, fmul_q};
		aprod = {16'd0, cur_amp_q} * {17'd0, amul_q};
		if (ridged_q) begin
			next_freq = {cur_freq_q[30:0], 1'b0};
		end else if (|fprod[47:44]) begin
			next_freq = '1;
		end else begin
			next_freq = fprod[43:12];
		end
		trial = {rem_q, (div_cnt_q == DIV_CNT_W'(DIV_EXP))};
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: state_d = ST_IDLE;
			ST_TABLE: begin
				if (tab_idx_q == IDX_W'(MAX_OCTAVES - 1)) state_d = ST_DIVIDE;
			end
			ST_DIVIDE: begin
				if (div_cnt_q == '0) state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
		if (cfg_hit) state_d = ST_TABLE;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_TABLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seed_q     <= '0;
			count_q    <= 4'd4;
			fmul_q     <= 16'd8192;
			amul_q     <= 16'd32768;
			ridged_q   <= 1'b0;
			tab_idx_q  <= '0;
			div_cnt_q  <= '0;
			cur_freq_q <= 32'(ONE_Q16);
			cur_amp_q  <= 17'(ONE_Q16);
			total_q    <= '0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					REG_SEED:   seed_q   <= cfg_wdata;
					REG_OCTAVE: count_q  <= cfg_wdata[3:0];
					REG_FREQ:   fmul_q   <= cfg_wdata[15:0];
					REG_AMP:    amul_q   <= cfg_wdata[15:0];
					REG_RIDGED: ridged_q <= cfg_wdata[0];
					default: ;
				endcase
			end
			if (cfg_hit) begin
				tab_idx_q  <= '0;
				cur_freq_q <= 32'(ONE_Q16);
				cur_amp_q  <= 17'(ONE_Q16);
				total_q    <= '0;
			end else if (state_q == ST_TABLE) begin
				tab_idx_q  <= tab_idx_q + 1'b1;
				cur_freq_q <= next_freq;
				cur_amp_q  <= aprod[32:16];
				if (OCT_W'(tab_idx_q) < oct_used) total_q <= total_q + TOT_W'(cur_amp_q);
				if (tab_idx_q == IDX_W'(MAX_OCTAVES - 1)) div_cnt_q <= DIV_CNT_W'(DIV_EXP);
			end else if (state_q == ST_DIVIDE && div_cnt_q != '0) begin
				div_cnt_q <= div_cnt_q - 1'b1;
			end
		end
	end

	// Table entries and divider datapath.
	always_ff @(posedge clk) begin
		if (state_q == ST_TABLE) begin
			freq_tab[tab_idx_q] <= cur_freq_q;
			amp_tab[tab_idx_q]  <= cur_amp_q;
			rem_q <= '0;
			quo_q <= '0;
		end else if (state_q == ST_DIVIDE) begin
			if (trial >= {1'b0, total_q}) begin
				rem_q <= TOT_W'(trial - {1'b0, total_q});
				quo_q <= {quo_q[RECIP_W-2:0], 1'b1};
			end else begin
				rem_q <= trial[TOT_W-1:0];
				quo_q <= {quo_q[RECIP_W-2:0], 1'b0};
			end
		end
	end

	assign setup.busy     = (state_q != ST_IDLE);
	assign setup.seed     = seed_q;
	assign setup.ridged   = ridged_q;
	assign setup.oct_used = oct_used;
	assign setup.recip    = quo_q;

`ifndef SYNTH
	a_total_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_DIVIDE |-> total_q != '0)
		else $error("amplitude total is zero during division");
	a_recip_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_IDLE && !cfg_hit) |=> $stable(quo_q))
		else $error("reciprocal changed while idle");
	a_write_restarts: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_hit |=> state_q == ST_TABLE)
		else $error("register write did not restart the table pass");
`endif

endmodule

>>> hw/rtl/fractal_perlin_noise_3d.sv
// ----------------------------------------------------------------------------
// fractal_perlin_noise_3d: layered 3D gradient noise, fbm or ridged
// Top level: octave lanes in parallel, octave weighting, a registered sum
// tree and fbm normalization, all on one stall-aware pipeline.
// ----------------------------------------------------------------------------
// Usage:
// A point (point_x, point_y, point_z, signed Q16.16) transfers on a rising
// edge with point_valid high and point_stall low. One noise_value (unsigned
// Q2.16) comes out per point on the result channel, in order, and transfers
// when noise_valid is high and noise_stall is low.
// There are 12 register stages, and a new point can transfer in every cycle
// that point_stall is low. All octaves run in their own lanes at once, so the
// octave count does not change the rate.
// When the receiver stalls, the last stage holds its result and the stages
// behind it keep filling until each holds an item; point_stall then rises
// when the first stage is full and cannot move.
// Reset and every write to a defined register start a coefficient pass
// (tables, then a bit-serial reciprocal) with point_stall high. Registers
// are written through cfg_we, cfg_index and cfg_wdata; the user must write
// them only while no point is in flight, which the block does not enforce.
// ----------------------------------------------------------------------------
module fractal_perlin_noise_3d #(
	parameter int MAX_OCTAVES = 8,
	parameter int FRAC_BITS = 16
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_we,
	input  logic [fpn3_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [31:0]                       cfg_wdata,
	input  logic                              point_valid,
	output logic                              point_stall,
	input  logic signed [31:0]                point_x,
	input  logic signed [31:0]                point_y,
	input  logic signed [31:0]                point_z,
	output logic                              noise_valid,
	input  logic                              noise_stall,
	output logic [17:0]                       noise_value
);
	import fpn3_pkg::*;

	localparam int NSTG = 12;
	localparam int NGRP = (MAX_OCTAVES + 3) / 4;
	localparam int GRP_W = 19;
	localparam int SUM_W = TOT_W;

	setup_t      setup;
	logic [31:0] freq_tab [MAX_OCTAVES];
	logic [16:0] amp_tab [MAX_OCTAVES];

	fpn3_setup #(
		.MAX_OCTAVES(MAX_OCTAVES)
	) u_setup (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_wdata(cfg_wdata),
		.setup(setup),
		.freq_tab(freq_tab),
		.amp_tab(amp_tab)
	);

	// A stage loads when it is empty or when the stage after it moves.
	logic [NSTG:1]   v_q;
	logic [NSTG+1:1] en;

	assign en[NSTG+1] = !noise_stall;
	for (genvar k = 1; k <= NSTG; k++) begin : g_en
		assign en[k] = !v_q[k] || en[k+1];
	end

	assign point_stall = setup.busy || !en[1];
	assign noise_valid = v_q[NSTG];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_q <= '0;
		end else begin
			if (en[1]) v_q[1] <= point_valid && !setup.busy;
			for (int k = 2; k <= NSTG; k++) begin
				if (en[k]) v_q[k] <= v_q[k-1];
			end
		end
	end

	// Octave lanes and per-octave weighting (stage 8).
	logic [16:0] contrib_s8 [MAX_OCTAVES];

	for (genvar i = 0; i < MAX_OCTAVES; i++) begin : g_lane
		logic [16:0] nv;
		logic [33:0] wprod;
		logic signed [18:0] rd;
		logic [16:0] rabs;
		logic [16:0] rval;

		fpn3_octave #(
			.FRAC_BITS(FRAC_BITS)
		) u_octave (
			.clk(clk),
			.en(en[LANE_STG:1]),
			.px(point_x),
			.py(point_y),
			.pz(point_z),
			.freq(freq_tab[i]),
			.seed(setup.seed + 32'(i)),
			.nv(nv)
		);

		always_comb begin
			wprod = {17'd0, nv} * {17'd0, amp_tab[i]};
			rd    = $signed({1'b0, nv, 1'b0}) - 19'sd65536;
			rabs  = rd[18] ? 17'(-rd) : rd[16:0];
			rval  = (17'(ONE_Q16) - rabs) >> i;
		end

		always_ff @(posedge clk) begin
			if (en[8]) begin
				if (OCT_W'(i) >= setup.oct_used) begin
					contrib_s8[i] <= '0;
				end else if (setup.ridged) begin
					contrib_s8[i] <= rval;
				end else begin
					contrib_s8[i] <= wprod[32:16];
				end
			end
		end
	end

	// Stage 9 sums groups of four octaves, stage 10 sums the groups.
	logic [GRP_W-1:0] grp_d [NGRP];
	logic [GRP_W-1:0] grp_s9 [NGRP];
	logic [SUM_W-1:0] sum_d;
	logic [SUM_W-1:0] sum_s10;

	always_comb begin
		for (int g = 0; g < NGRP; g++) begin
			grp_d[g] = '0;
			for (int j = 0; j < 4; j++) begin
				if (4 * g + j < MAX_OCTAVES) grp_d[g] = grp_d[g] + GRP_W'(contrib_s8[4*g+j]);
			end
		end
		sum_d = '0;
		for (int g = 0; g < NGRP; g++) begin
			sum_d = sum_d + SUM_W'(grp_s9[g]);
		end
	end

	always_ff @(posedge clk) begin
		if (en[9]) grp_s9 <= grp_d;
		if (en[10]) sum_s10 <= sum_d;
	end

	// Stage 11: sum times reciprocal as two partial products.
	logic [SUM_W+16:0] plo_s11;
	logic [SUM_W+15:0] phi_s11;
	logic [SUM_W-1:0]  sum_s11;

	always_ff @(posedge clk) begin
		if (en[11]) begin
			plo_s11 <= {17'd0, sum_s10} * {SUM_W'(0), setup.recip[16:0]};
			phi_s11 <= {16'd0, sum_s10} * {SUM_W'(0), setup.recip[32:17]};
			sum_s11 <= sum_s10;
		end
	end

	// Stage 12: combine, take the top bits and clamp fbm to 1.0.
	logic [54:0] full;
	logic [22:0] normed;
	logic [17:0] res_d;
	logic [17:0] noise_s12;

	always_comb begin
		full   = 55'(plo_s11) + (55'(phi_s11) << 17);
		normed = full[54:32];
		if (setup.ridged) begin
			res_d = sum_s11[17:0];
		end else if (normed > 23'(ONE_Q16)) begin
			res_d = 18'(ONE_Q16);
		end else begin
			res_d = normed[17:0];
		end
	end

	always_ff @(posedge clk) begin
		if (en[12]) noise_s12 <= res_d;
	end

	assign noise_value = noise_s12;

`ifndef SYNTH
	a_busy_stalls: assert property (@(posedge clk) disable iff (!arst_n)
		setup.busy |-> point_stall)
		else $error("input not stalled during coefficient pass");
	a_fbm_range: assert property (@(posedge clk) disable iff (!arst_n)
		(noise_valid && !setup.ridged) |-> noise_value <= 18'd65536)
		else $error("fbm result above 1.0");
	a_enter: assert property (@(posedge clk) disable iff (!arst_n)
		(point_valid && !point_stall) |=> v_q[1])
		else $error("accepted point missing from first stage");
	a_reach_out: assert property (@(posedge clk) disable iff (!arst_n)
		(v_q[NSTG-1] && en[NSTG]) |=> noise_valid)
		else $error("item lost before the output stage");
`endif

endmodule
